FILE: sv/skbs_pkg.sv
// Shared types and constants for the sorted key binary search block.
// No dependencies; imported by skbs_ctrl, skbs_dp and the top level.
package skbs_pkg;

    localparam int OID_W  = 64;
    localparam int TYPE_W = 8;
    localparam int OFF_W  = 64;
    localparam int KEY_W  = OID_W + TYPE_W + OFF_W;
    localparam int SLOT_W = 10;

    typedef enum logic [1:0] {
        MODE_LOAD = 2'd0,
        MODE_SRCH = 2'd1,
        MODE_CHK  = 2'd2,
        MODE_NONE = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_COUNT = 2'd1,
        ST_BAD_ORDER = 2'd2,
        ST_OVERFLOW  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SPROBE,
        S_SCMP,
        S_CRD,
        S_CCMP,
        S_DONE
    } t_state;

    // Input word: key parts are ordered most to least significant
    typedef struct packed {
        t_mode              mode;
        logic               restart;
        logic [OID_W-1:0]   key_objectid;
        logic [TYPE_W-1:0]  key_kind;
        logic [OFF_W-1:0]   key_offset;
    } t_in_word;

    typedef struct packed {
        logic               found;
        logic [SLOT_W-1:0]  slot;
        t_status            status;
    } t_out_word;

    // Commands from controller to datapath
    typedef struct packed {
        logic capture;
        logic exec;
        logic probe;
        logic srch_step;
        logic srch_end;
        logic chk_rd;
        logic chk_step;
        logic out_load;
    } t_dp_cmd;

    // Status from datapath to controller
    typedef struct packed {
        t_mode mode;
        logic  lo_lt_hi;
        logic  key_eq;
        logic  cnt_zero;
        logic  chk_bad;
        logic  chk_last;
        logic  out_ok;
    } t_dp_status;

endpackage

FILE: sv/sorted_key_binary_search.sv
// Top level of the sorted key binary search block.
// Depends on skbs_pkg; instantiates skbs_ctrl and skbs_dp.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_word) takes one word per
//   operation: mode 0 appends a key (restart empties the set first), mode 1
//   runs a lower-bound binary search, mode 2 checks count and strict order.
//   Output channel (o_out_valid / i_out_stall / o_out_word) returns exactly
//   one word per accepted input word, in order.
// Sequencing (N = entries loaded; next word taken once a result is loaded):
//   Load or mode 3: capture, execute, then load the result.
//   Search: capture, execute, then a probe read and a compare per probe,
//     at most ceil(log2(N+1)) probes; an exact hit ends the search at its compare.
//   Check: a read and a compare per stored entry, ending early on a bad pair.
//   Every probe and check step costs a read of the two-port key memory,
//   whose read data is registered, then a 136-bit compare.
// Reset clears the entry count and the control state; the key memory needs
//   no clearing since only loaded entries are ever read.
// A stalled result sits in the output register; one more word is taken
//   and worked on meanwhile, and its result waits until the register frees.
module sorted_key_binary_search #(
    parameter int MAX_ENTRIES = 512
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  skbs_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output skbs_pkg::t_out_word o_out_word
);
    import skbs_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_st;

    // Sequencer
    skbs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_st       (w_st),
        .o_cmd      (w_cmd)
    );

    // Key store and compare datapath
    skbs_dp #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_st        (w_st),
        .i_in_word   (i_in_word),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

endmodule

FILE: sv/skbs_ctrl.sv
// Controller state machine for the sorted key binary search block.
// Depends on skbs_pkg; drives skbs_dp through t_dp_cmd and reads t_dp_status.
module skbs_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  skbs_pkg::t_dp_status i_st,
    output skbs_pkg::t_dp_cmd    o_cmd
);
    import skbs_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (i_st.mode)
                    MODE_SRCH: n_state = S_SPROBE;
                    MODE_CHK:  n_state = i_st.cnt_zero ? S_DONE : S_CRD;
                    default:   n_state = S_DONE;
                endcase
            end
            S_SPROBE: begin
                n_state = i_st.lo_lt_hi ? S_SCMP : S_DONE;
            end
            S_SCMP: begin
                n_state = i_st.key_eq ? S_DONE : S_SPROBE;
            end
            S_CRD: begin
                n_state = S_CCMP;
            end
            S_CCMP: begin
                n_state = (i_st.chk_bad || i_st.chk_last) ? S_DONE : S_CRD;
            end
            S_DONE: begin
                if (i_st.out_ok) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Command outputs
    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall    = 1'b0;
                o_cmd.capture = i_in_valid;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
            end
            S_SPROBE: begin
                o_cmd.probe    = i_st.lo_lt_hi;
                o_cmd.srch_end = !i_st.lo_lt_hi;
            end
            S_SCMP: begin
                o_cmd.srch_step = 1'b1;
            end
            S_CRD: begin
                o_cmd.chk_rd = 1'b1;
            end
            S_CCMP: begin
                o_cmd.chk_step = 1'b1;
            end
            S_DONE: begin
                o_cmd.out_load = i_st.out_ok;
            end
            default: o_cmd = '0;
        endcase
    end

    // A result is only pushed into a free output register
    a_load_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_st.out_ok)
        else $error("result loaded while output register busy");

    // An accepted word is always dispatched in the following cycle
    a_accept_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> (r_state == S_EXEC))
        else $error("accepted word not dispatched");

endmodule

FILE: sv/skbs_dp.sv
// Datapath for the sorted key binary search block: key memory, count,
// search bounds, order check and output register. Depends on skbs_pkg.
module skbs_dp #(
    parameter int MAX_ENTRIES = 512
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  skbs_pkg::t_dp_cmd    i_cmd,
    output skbs_pkg::t_dp_status o_st,
    input  skbs_pkg::t_in_word   i_in_word,
    input  logic                 i_out_stall,
    output logic                 o_out_valid,
    output skbs_pkg::t_out_word  o_out_word
);
    import skbs_pkg::*;

    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    logic [KEY_W-1:0] r_mem [MAX_ENTRIES];

    t_mode            r_mode;
    logic             r_restart;
    logic [KEY_W-1:0] r_key;
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    r_lo;
    logic [CW-1:0]    r_hi;
    logic [AW-1:0]    r_mid;
    logic [AW-1:0]    r_idx;
    logic [KEY_W-1:0] r_rdata;
    logic [KEY_W-1:0] r_prev;
    t_out_word        r_res;
    t_out_word        r_out;
    logic             r_out_vld;

    logic [CW:0]      w_mid_sum;
    logic [AW-1:0]    w_mid;
    logic [AW-1:0]    w_rd_addr;
    logic [CW-1:0]    w_cnt_eff;
    logic             w_ovf;
    logic [CW-1:0]    w_cnt_new;
    logic             w_key_lt;
    logic             w_key_eq;
    logic             w_chk_bad;
    logic             w_chk_last;
    logic             w_out_ok;

    // Midpoint of the search window
    assign w_mid_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid     = w_mid_sum[AW:1];

    // Load: effective count after a restart, overflow and new count
    assign w_cnt_eff = r_restart ? '0 : r_count;
    assign w_ovf     = (w_cnt_eff >= CW'(MAX_ENTRIES));
    assign w_cnt_new = w_ovf ? w_cnt_eff : (w_cnt_eff + CW'(1));

    // Compare stored key against the search key, and adjacent stored keys
    assign w_key_lt   = (r_rdata < r_key);
    assign w_key_eq   = (r_rdata == r_key);
    assign w_chk_bad  = (r_idx != '0) && !(r_prev < r_rdata);
    assign w_chk_last = ((CW'(r_idx) + CW'(1)) == r_count);

    assign w_out_ok  = !r_out_vld || !i_out_stall;
    assign w_rd_addr = i_cmd.probe ? w_mid : r_idx;

    // Capture the accepted word
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode    <= i_in_word.mode;
            r_restart <= i_in_word.restart;
            r_key     <= {i_in_word.key_objectid, i_in_word.key_kind,
                          i_in_word.key_offset};
        end
    end

    // Key memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && (r_mode == MODE_LOAD) && !w_ovf) begin
            r_mem[w_cnt_eff[AW-1:0]] <= r_key;
        end
        if (i_cmd.probe || i_cmd.chk_rd) begin
            r_rdata <= r_mem[w_rd_addr];
        end
    end

    // Entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.exec && (r_mode == MODE_LOAD)) begin
            r_count <= w_cnt_new;
        end
    end

    // Search bounds, check index and pending result
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_lo  <= '0;
            r_hi  <= r_count;
            r_idx <= '0;
            case (r_mode)
                MODE_LOAD: begin
                    r_res <= '{found: 1'b0, slot: SLOT_W'(w_cnt_new),
                               status: (w_ovf ? ST_OVERFLOW : ST_OK)};
                end
                MODE_CHK: begin
                    r_res <= '{found: 1'b0, slot: SLOT_W'(r_count),
                               status: ((r_count == '0) ? ST_BAD_COUNT : ST_OK)};
                end
                default: begin
                    r_res <= '{found: 1'b0, slot: '0, status: ST_OK};
                end
            endcase
        end
        if (i_cmd.probe) begin
            r_mid <= w_mid;
        end
        if (i_cmd.srch_step) begin
            if (w_key_eq) begin
                r_res <= '{found: 1'b1, slot: SLOT_W'(r_mid), status: ST_OK};
            end else if (w_key_lt) begin
                r_lo <= CW'(r_mid) + CW'(1);
            end else begin
                r_hi <= CW'(r_mid);
            end
        end
        if (i_cmd.srch_end) begin
            r_res <= '{found: 1'b0, slot: SLOT_W'(r_lo), status: ST_OK};
        end
        if (i_cmd.chk_step) begin
            r_prev <= r_rdata;
            r_idx  <= r_idx + AW'(1);
            if (w_chk_bad) begin
                r_res.status <= ST_BAD_ORDER;
            end
        end
    end

    // Output register: drop on take, fill on load
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out;

    assign o_st = '{mode: r_mode, lo_lt_hi: (r_lo < r_hi), key_eq: w_key_eq,
                    cnt_zero: (r_count == '0), chk_bad: w_chk_bad,
                    chk_last: w_chk_last, out_ok: w_out_ok};

    // Count never passes capacity
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_ENTRIES))
        else $error("entry count above capacity");

    // An overflowing load leaves the count alone
    a_ovf_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && (r_mode == MODE_LOAD) && w_ovf) |=> $stable(r_count))
        else $error("count changed on overflowing load");

endmodule
